// ===== rtl/dics_pkg.sv =====
package dics_pkg;

  // table geometry
  localparam int MAX_ENTRIES_DEF = 256;

  // field widths
  localparam int CMD_W   = 2;
  localparam int VAL_W   = 16;
  localparam int DEN_W   = 16;
  localparam int U_W     = 16;
  localparam int WT_W    = 16;
  localparam int STS_W   = 2;
  localparam int TOTAL_W = 24;

  // product of u and the density total
  localparam int TARGET_W = U_W + TOTAL_W;

  // weight numerator is total * 256
  localparam int WT_FRAC = 8;
  localparam int NUM_W   = TOTAL_W + WT_FRAC;

  // lookup mode: u is mapped onto 1024 steps of 64
  localparam int LUT_IDX_W = 10;
  localparam int LUT_PROD_W = U_W + LUT_IDX_W;
  localparam logic [LUT_IDX_W-1:0] LUT_SCALE = 10'd1023;
  localparam int LUT_STEP_SH = U_W - LUT_IDX_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SAMPLE = 2'd2
  } cmd_code_t;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_MISS  = 2'd1;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TARGET,
    S_SCAN,
    S_WEIGHT,
    S_DIVIDE,
    S_HIT,
    S_MISS
  } state_t;

  typedef enum logic [2:0] {
    RES_OK,
    RES_FULL,
    RES_EMPTY,
    RES_MISS,
    RES_HIT
  } res_kind_t;

  // controller to datapath
  typedef struct packed {
    logic      op_clear;
    logic      op_append;
    logic      op_load;
    logic      op_target;
    logic      op_scan;
    logic      op_weight;
    logic      op_divide;
    logic      res_write;
    res_kind_t res_kind;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
    logic table_empty;
    logic append_full;
    logic chk_match;
    logic chk_last;
    logic div_done;
  } dp_sts_t;

endpackage

// ===== rtl/dics_if.sv =====
interface dics_in_if import dics_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [VAL_W-1:0] entry_value;
  logic [DEN_W-1:0] entry_density;
  logic [U_W-1:0]   canonical;

  modport source (output valid, command, entry_value, entry_density, canonical,
                  input ready);
  modport sink   (input valid, command, entry_value, entry_density, canonical,
                  output ready);
endinterface

interface dics_out_if import dics_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] sample_value;
  logic [WT_W-1:0]  weight;
  logic [STS_W-1:0] status;

  modport source (output valid, sample_value, weight, status, input ready);
  modport sink   (input valid, sample_value, weight, status, output ready);
endinterface

// ===== rtl/dics_ctrl.sv =====
module dics_ctrl import dics_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_ready,
  input  dp_sts_t          sts,
  output dp_cmd_t          cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && in_command == CMD_SAMPLE && !sts.table_empty) begin
          state_next = S_TARGET;
        end
      end
      S_TARGET: state_next = S_SCAN;
      S_SCAN: begin
        if (sts.chk_match) begin
          state_next = S_WEIGHT;
        end else if (sts.chk_last) begin
          state_next = S_MISS;
        end
      end
      S_WEIGHT: state_next = S_DIVIDE;
      S_DIVIDE: begin
        if (sts.div_done) begin
          state_next = S_HIT;
        end
      end
      S_HIT, S_MISS: begin
        if (!sts.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.res_kind = RES_OK;
    case (state)
      S_IDLE: begin
        in_ready = !sts.out_busy;
        if (accept) begin
          cmd.res_write = 1'b1;
          case (in_command)
            CMD_CLEAR: cmd.op_clear = 1'b1;
            CMD_APPEND: begin
              if (sts.append_full) begin
                cmd.res_kind = RES_FULL;
              end else begin
                cmd.op_append = 1'b1;
              end
            end
            CMD_SAMPLE: begin
              if (sts.table_empty) begin
                cmd.res_kind = RES_EMPTY;
              end else begin
                cmd.res_write = 1'b0;
                cmd.op_load   = 1'b1;
              end
            end
            default: cmd.res_kind = RES_OK;
          endcase
        end
      end
      S_TARGET: cmd.op_target = 1'b1;
      S_SCAN:   cmd.op_scan   = 1'b1;
      S_WEIGHT: cmd.op_weight = 1'b1;
      S_DIVIDE: cmd.op_divide = !sts.div_done;
      S_HIT: begin
        cmd.res_write = !sts.out_busy;
        cmd.res_kind  = RES_HIT;
      end
      S_MISS: begin
        cmd.res_write = !sts.out_busy;
        cmd.res_kind  = RES_MISS;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/dics_dp.sv =====
module dics_dp import dics_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  logic [VAL_W-1:0] in_entry_value,
  input  logic [DEN_W-1:0] in_entry_density,
  input  logic [U_W-1:0]   in_canonical,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [VAL_W-1:0] out_sample_value,
  output logic [WT_W-1:0]  out_weight,
  output logic [STS_W-1:0] out_status,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts
);

  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int DW    = CW + DEN_W;
  localparam int CUM_W = TOTAL_W + 1;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);
  localparam int MEM_W = VAL_W + DEN_W;

  // table store, value in the upper half
  logic [MEM_W-1:0] mem [MAX_ENTRIES];

  logic                 use_lut;
  logic [CW-1:0]        count;
  logic [TOTAL_W-1:0]   total;
  logic [TOTAL_W:0]     total_sum;

  logic [LUT_PROD_W-1:0] lut_prod;
  logic [U_W-1:0]        u_q;
  logic [U_W-1:0]        u_reg;
  logic [TARGET_W-1:0]   target;

  logic [CW-1:0]        rd_idx;
  logic                 issue;
  logic                 chk_valid;
  logic [CW-1:0]        chk_idx;
  logic [VAL_W-1:0]     rd_value;
  logic [DEN_W-1:0]     rd_density;
  logic [CUM_W-1:0]     cum;
  logic [CUM_W-1:0]     cum_hi;
  logic [TARGET_W:0]    span_lo;
  logic [TARGET_W:0]    span_hi;
  logic                 hit;

  logic [VAL_W-1:0]     sel_value;
  logic [DEN_W-1:0]     sel_density;

  logic [DW-1:0]        den;
  logic [DW-1:0]        rem;
  logic [NUM_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DW:0]          rem_sh;
  logic [DW:0]          diff;
  logic [WT_W-1:0]      w_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_lut <= 1'b0;
    end else if (cfg_wr_en) begin
      use_lut <= cfg_wr_data;
    end
  end

  // table bookkeeping
  assign total_sum = {1'b0, total} + (TOTAL_W + 1)'(in_entry_density);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else if (cmd.op_clear) begin
      count <= '0;
      total <= '0;
    end else if (cmd.op_append) begin
      count <= count + CW'(1);
      total <= total_sum[TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op_append) begin
      mem[count[AW-1:0]] <= {in_entry_value, in_entry_density};
    end
    if (issue) begin
      {rd_value, rd_density} <= mem[rd_idx[AW-1:0]];
    end
  end

  // lookup mode quantization
  assign lut_prod = LUT_PROD_W'(in_canonical) * LUT_PROD_W'(LUT_SCALE);
  assign u_q = use_lut ? {lut_prod[LUT_PROD_W-1 -: LUT_IDX_W], {LUT_STEP_SH{1'b0}}}
                       : in_canonical;

  always_ff @(posedge clk) begin
    if (cmd.op_load) begin
      u_reg <= u_q;
    end
    if (cmd.op_target) begin
      target <= TARGET_W'(u_reg) * TARGET_W'(total);
    end
  end

  // scan: one read issued per cycle, checked the cycle after
  assign issue = cmd.op_scan && (rd_idx < count);

  assign cum_hi  = cum + CUM_W'(rd_density);
  assign span_lo = {cum, {U_W{1'b0}}};
  assign span_hi = {cum_hi, {U_W{1'b0}}};
  assign hit = (rd_density != '0) && (span_lo <= (TARGET_W + 1)'(target))
            && ((TARGET_W + 1)'(target) <= span_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else if (cmd.op_load) begin
      chk_valid <= 1'b0;
    end else begin
      chk_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op_load) begin
      rd_idx <= '0;
      cum    <= '0;
    end else begin
      if (issue) begin
        rd_idx  <= rd_idx + CW'(1);
        chk_idx <= rd_idx;
      end
      if (cmd.op_scan && chk_valid) begin
        cum         <= cum_hi;
        sel_value   <= rd_value;
        sel_density <= rd_density;
      end
    end
  end

  // weight: restoring division of total*256 by count*d
  assign rem_sh = {rem, quo[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.op_weight) begin
      div_cnt <= DIV_CNT_W'(NUM_W);
    end else if (cmd.op_divide) begin
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op_weight) begin
      den <= DW'(count) * DW'(sel_density);
      rem <= '0;
      quo <= {total, {WT_FRAC{1'b0}}};
    end else if (cmd.op_divide) begin
      if (!diff[DW]) begin
        rem <= diff[DW-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DW-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign w_sat = (quo[NUM_W-1:WT_W] != '0) ? {WT_W{1'b1}} : quo[WT_W-1:0];

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_write) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_write) begin
      case (cmd.res_kind)
        RES_OK: begin
          out_sample_value <= '0;
          out_weight       <= '0;
          out_status       <= STS_OK;
        end
        RES_FULL: begin
          out_sample_value <= '0;
          out_weight       <= '0;
          out_status       <= STS_FULL;
        end
        RES_EMPTY: begin
          out_sample_value <= '0;
          out_weight       <= '0;
          out_status       <= STS_EMPTY;
        end
        RES_MISS: begin
          out_sample_value <= sel_value;
          out_weight       <= '0;
          out_status       <= STS_MISS;
        end
        RES_HIT: begin
          out_sample_value <= sel_value;
          out_weight       <= w_sat;
          out_status       <= STS_OK;
        end
        default: begin
          out_sample_value <= '0;
          out_weight       <= '0;
          out_status       <= STS_OK;
        end
      endcase
    end
  end

  always_comb begin
    sts.out_busy    = out_valid && !out_ready;
    sts.table_empty = (count == '0) || (total == '0);
    sts.append_full = (count >= CW'(MAX_ENTRIES)) || total_sum[TOTAL_W];
    sts.chk_match   = cmd.op_scan && chk_valid && hit;
    sts.chk_last    = cmd.op_scan && chk_valid && (chk_idx == count - CW'(1));
    sts.div_done    = (div_cnt == '0);
  end

endmodule

// ===== rtl/discrete_inverse_cdf_sampler_top.sv =====
// discrete inverse-cdf sampler: keeps up to MAX_ENTRIES (value, density) pairs and
// maps a uniform fraction u (q0.16) onto the first entry with nonzero density whose
// cumulative span covers u*total, returning its value and the importance weight
// total*256/(count*d) in q8.8, saturated to 16 bits. clear, append and unused
// command codes, and a sample on an empty table or zero total, give their result
// beat in the cycle after the input beat. a sample that hits does the u*total
// multiply, reads the table one entry per cycle through the single read port of
// the table memory, does the count*d multiply and the 32-step bit-serial weight
// division, then writes the result and returns to idle to take the next beat. a
// sample that misses skips the division. one beat is worked on at a time; a new
// input beat is taken only when the result register is empty or its beat leaves
// in the same cycle.
module discrete_inverse_cdf_sampler_top import dics_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // use_lut register write
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  dics_in_if.sink    req,
  dics_out_if.source rsp
);

  // command and status between sequencer and datapath
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic    ctrl_ready;

  // sequencer: decodes the command beat and steps load, multiply, scan, divide
  dics_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_command (req.command),
    .in_ready   (ctrl_ready),
    .sts        (dp_sts),
    .cmd        (dp_cmd)
  );

  // datapath: table memory, totals, scan compare, divider and result register
  dics_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_entry_value   (req.entry_value),
    .in_entry_density (req.entry_density),
    .in_canonical     (req.canonical),
    .out_ready        (rsp.ready),
    .out_valid        (rsp.valid),
    .out_sample_value (rsp.sample_value),
    .out_weight       (rsp.weight),
    .out_status       (rsp.status),
    .cmd              (dp_cmd),
    .sts              (dp_sts)
  );

  // input beats are taken only in idle with the result register free or draining
  assign req.ready = ctrl_ready;

endmodule

// ===== sim/tb_top.sv =====
module tb_top import dics_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // command code that the block takes and ignores
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // largest density sum the 24-bit total holds
  localparam logic [31:0] TOTAL_LIMIT = (32'd1 << TOTAL_W) - 32'd1;
  // cycles without any beat before the run is called hung
  localparam int QUIET_LIMIT = 20000;
  // cycles to watch for stray results once nothing is outstanding
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [VAL_W-1:0] sample_value;
    logic [WT_W-1:0]  weight;
    logic [STS_W-1:0] status;
  } outcome_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  dics_in_if  req_if ();
  dics_out_if rsp_if ();

  discrete_inverse_cdf_sampler_top #(
    .MAX_ENTRIES (MAX_ENTRIES_DEF)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_if),
    .rsp         (rsp_if)
  );

  // predictor copy of the table, its count and sum, and the lookup mode
  logic [VAL_W-1:0]   tbl_value   [MAX_ENTRIES_DEF];
  logic [DEN_W-1:0]   tbl_density [MAX_ENTRIES_DEF];
  int                 tbl_count;
  logic [TOTAL_W-1:0] tbl_total;
  logic               lut_mode;

  // outcomes predicted for accepted commands, oldest first
  outcome_t outcome_q[$];

  // per-cycle idle odds in percent for each side
  int send_idle_pct;
  int recv_idle_pct;

  int mismatch_count;
  int n_commands;
  int n_checked;
  int n_matched;
  int n_empty_draws;
  int n_refused;
  int n_lut_draws;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // expected outcome of one command; advances the predictor table
  function automatic outcome_t sampler_outcome(input logic [CMD_W-1:0] cmd,
                                               input logic [VAL_W-1:0] val,
                                               input logic [DEN_W-1:0] den,
                                               input logic [U_W-1:0]   u);
    outcome_t    res;
    logic [31:0] grown;
    logic [U_W-1:0] frac;
    logic [63:0] target;
    logic [63:0] span_lo;
    logic [63:0] d;
    logic [63:0] wt;
    bit          found;
    res = '0;
    case (cmd)
      CMD_CLEAR: begin
        tbl_count = 0;
        tbl_total = '0;
      end
      CMD_APPEND: begin
        grown = 32'(tbl_total) + 32'(den);
        // refused when the table is at its limit or the sum would overflow
        if (tbl_count >= MAX_ENTRIES_DEF || grown > TOTAL_LIMIT) begin
          res.status = STS_FULL;
          n_refused++;
        end else begin
          tbl_value[tbl_count]   = val;
          tbl_density[tbl_count] = den;
          tbl_count++;
          tbl_total = grown[TOTAL_W-1:0];
        end
      end
      CMD_SAMPLE: begin
        if (tbl_count == 0 || tbl_total == '0) begin
          res.status = STS_EMPTY;
          n_empty_draws++;
        end else begin
          // lookup mode snaps u onto the 1024-step grid
          if (lut_mode) begin
            frac = U_W'(((32'(u) * 32'(LUT_SCALE)) >> U_W) << LUT_STEP_SH);
            n_lut_draws++;
          end else begin
            frac = u;
          end
          target  = 64'(frac) * 64'(tbl_total);
          span_lo = '0;
          found   = 1'b0;
          // first nonzero entry whose span covers u*total, both ends inclusive
          for (int k = 0; k < tbl_count && !found; k++) begin
            d = 64'(tbl_density[k]);
            if (d != 0 && (span_lo << 16) <= target && target <= ((span_lo + d) << 16)) begin
              found = 1'b1;
              wt = (64'(tbl_total) << WT_FRAC) / (64'(tbl_count) * d);
              res.sample_value = tbl_value[k];
              res.weight       = (wt > 64'hFFFF) ? '1 : wt[WT_W-1:0];
              n_matched++;
            end else begin
              span_lo = span_lo + d;
            end
          end
          if (!found) begin
            res.sample_value = tbl_value[tbl_count-1];
            res.status       = STS_MISS;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // append one prediction at the tail of the outstanding list
  task automatic enqueue_outcome(input outcome_t item);
    outcome_q.insert(outcome_q.size(), item);
  endtask

  // densities weighted toward zero, tiny and full-scale values
  function automatic logic [DEN_W-1:0] rand_density();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return '0;
    if (pick < 40) return DEN_W'($urandom_range(15, 1));
    if (pick < 55) return '1;
    return DEN_W'($urandom);
  endfunction

  // fractions with extra weight on both ends of the range
  function automatic logic [U_W-1:0] rand_fraction();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 20) return '1;
    return U_W'($urandom);
  endfunction

  // drive one command beat, wait for it to be taken, queue its outcome
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                           input logic [DEN_W-1:0] den, input logic [U_W-1:0] u);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.command       <= cmd;
    req_if.entry_value   <= val;
    req_if.entry_density <= den;
    req_if.canonical     <= u;
    do @(posedge clk); while (!req_if.ready);
    enqueue_outcome(sampler_outcome(cmd, val, den, u));
    n_commands++;
  endtask

  // stop sending until every outstanding result has come back
  task automatic drain_outcomes();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  // lookup mode register, written only while the block is quiet
  task automatic write_lut_mode(input logic mode);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    lut_mode = mode;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // field extremes, empty and zero-sum tables, span boundaries, saturation
  task automatic test_directed_edges();
    send_beat(CMD_SAMPLE, '1, '1, '1);              // draw from an empty table
    send_beat(CMD_UNUSED, '1, '1, '1);              // unused code is ignored
    send_beat(CMD_APPEND, '1, '0, '0);              // zero density only
    send_beat(CMD_SAMPLE, '0, '0, 16'h8000);        // zero sum with one entry
    send_beat(CMD_APPEND, '0, 16'h0001, '1);        // tiny density first
    send_beat(CMD_APPEND, '1, '1, '0);
    send_beat(CMD_APPEND, 16'h5A5A, '0, 16'h5A5A);
    send_beat(CMD_APPEND, 16'hA5A5, 16'h0001, '0);
    send_beat(CMD_SAMPLE, '0, '0, '0);              // weight saturates here
    send_beat(CMD_SAMPLE, '0, '0, '1);
    send_beat(CMD_SAMPLE, '0, '0, 16'h8000);
    send_beat(CMD_CLEAR, '1, '1, '1);
    send_beat(CMD_SAMPLE, '0, '0, 16'h1234);        // cleared table reads empty
    send_beat(CMD_APPEND, 16'h1111, 16'h0001, '0);
    send_beat(CMD_APPEND, 16'h2222, 16'h0001, '0);
    send_beat(CMD_SAMPLE, '0, '0, 16'h8000);        // exactly on the shared edge
    send_beat(CMD_SAMPLE, '0, '0, 16'h8001);
    send_beat(CMD_SAMPLE, '0, '0, 16'h7FFF);
  endtask

  // grid points and points just past them with lookup mode on
  task automatic test_lookup_grid();
    send_beat(CMD_CLEAR, '0, '0, '0);
    send_beat(CMD_APPEND, 16'h0101, 16'h0001, '0);
    send_beat(CMD_APPEND, 16'h0202, '0, '0);
    send_beat(CMD_APPEND, 16'h0303, 16'h0003, '0);
    send_beat(CMD_SAMPLE, '0, '0, '1);
    send_beat(CMD_SAMPLE, '0, '0, 16'h0040);
    send_beat(CMD_SAMPLE, '0, '0, 16'h4000);
    send_beat(CMD_SAMPLE, '0, '0, 16'h4041);
  endtask

  // fill every slot, overfill once, then draw from the full table
  task automatic test_full_table();
    int i;
    send_beat(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
    for (i = 0; i < MAX_ENTRIES_DEF; i++) begin
      send_beat(CMD_APPEND, 16'($urandom),
                ($urandom_range(3) == 0) ? '1 : rand_density(), 16'($urandom));
    end
    send_beat(CMD_APPEND, '1, '1, '0);              // no room left
    send_beat(CMD_SAMPLE, '0, '0, '0);
    send_beat(CMD_SAMPLE, '0, '0, '1);
    send_beat(CMD_SAMPLE, '0, '0, rand_fraction());
    send_beat(CMD_SAMPLE, '0, '0, rand_fraction());
    send_beat(CMD_CLEAR, '0, '0, '0);
  endtask

  // mostly clear/append/draw sequences with random content, some noise mixed in
  task automatic test_random_draws(input int n_items);
    int sent;
    int n_app;
    int n_draw;
    int j;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        // stray command of any code
        send_beat(CMD_W'($urandom_range(3)), 16'($urandom), rand_density(), rand_fraction());
        sent++;
      end else begin
        // sometimes keep growing the old table instead of starting over
        if (tbl_count > 200 || $urandom_range(3) != 0) begin
          send_beat(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
          sent++;
        end
        n_app = ($urandom_range(9) == 0) ? $urandom_range(48, 7) : $urandom_range(6, 1);
        for (j = 0; j < n_app; j++) begin
          send_beat(CMD_APPEND, 16'($urandom), rand_density(), 16'($urandom));
          sent++;
        end
        n_draw = $urandom_range(5, 1);
        for (j = 0; j < n_draw; j++) begin
          send_beat(CMD_SAMPLE, 16'($urandom), 16'($urandom), rand_fraction());
          sent++;
        end
      end
      // now and then hold off until the block has answered everything
      if ($urandom_range(99) < 3) drain_outcomes();
    end
  endtask

  // result side: random backpressure, changed on the falling edge
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare every result beat with the oldest prediction
  always @(posedge clk) begin : check_outcomes
    outcome_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      n_checked++;
      if (outcome_q.size() == 0) begin
        $error("result beat with nothing outstanding: sample_value %h weight %h status %h",
               rsp_if.sample_value, rsp_if.weight, rsp_if.status);
        mismatch_count++;
      end else begin
        want = outcome_q.pop_front();
        if (rsp_if.sample_value !== want.sample_value) begin
          $error("sample_value: expected %h, got %h", want.sample_value, rsp_if.sample_value);
          mismatch_count++;
        end
        if (rsp_if.weight !== want.weight) begin
          $error("weight: expected %h, got %h", want.weight, rsp_if.weight);
          mismatch_count++;
        end
        if (rsp_if.status !== want.status) begin
          $error("status: expected %h, got %h", want.status, rsp_if.status);
          mismatch_count++;
        end
      end
    end
  end

  // hang detector: too long without a beat on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    // every input known from time zero, with reset held high at the start
    rst                  = 1'b1;
    cfg_wr_en            = 1'b0;
    cfg_wr_data          = 1'b0;
    req_if.valid         = 1'b0;
    req_if.command       = CMD_CLEAR;
    req_if.entry_value   = '0;
    req_if.entry_density = '0;
    req_if.canonical     = '0;
    tbl_count            = 0;
    tbl_total            = '0;
    lut_mode             = 1'b0;
    send_idle_pct        = 8;
    recv_idle_pct        = 74;
    mismatch_count       = 0;
    n_commands           = 0;
    n_checked            = 0;
    n_matched            = 0;
    n_empty_draws        = 0;
    n_refused            = 0;
    n_lut_draws          = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sender mostly busy, receiver mostly stalled
    write_lut_mode(1'b0);
    test_directed_edges();
    test_random_draws(140);
    drain_outcomes();
    write_lut_mode(1'b1);
    test_lookup_grid();
    test_random_draws(140);

    // sender mostly idle, receiver mostly ready
    drain_outcomes();
    send_idle_pct = 74;
    recv_idle_pct = 8;
    write_lut_mode(1'b0);
    test_full_table();
    test_random_draws(100);

    // back to back on both sides
    drain_outcomes();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_lut_mode(1'b1);
    test_random_draws(100);
    drain_outcomes();
    write_lut_mode(1'b0);
    test_random_draws(60);

    // all answered, then watch a while for anything extra
    drain_outcomes();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d commands, %0d results checked: %0d draws matched (%0d on the lookup grid),",
             n_commands, n_checked, n_matched, n_lut_draws);
    $display("%0d draws on empty or zero-sum tables, %0d appends refused on a full table",
             n_empty_draws, n_refused);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
